// ===== src/nfmt_pkg.sv =====
// shared types, format codes and character helpers for the number formatter
package nfmt_pkg;

   // format selector codes
   localparam logic [1:0] OP_DEC    = 2'd0;
   localparam logic [1:0] OP_HEX_UP = 2'd1;
   localparam logic [1:0] OP_HEX_LO = 2'd2;
   localparam logic [1:0] OP_PTR    = 2'd3;

   localparam int BIN_BITS  = 32;
   localparam int BCD_DIGS  = 10;
   localparam int HEX32_DIG = 8;
   localparam int HEX64_DIG = 16;
   localparam int NIL_LEN   = 5;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] UPPER_BASE = 8'h37; // 'A' - 10
   localparam logic [7:0] LOWER_BASE = 8'h57; // 'a' - 10

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_PREFIX,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      if (d < 4'd10) begin
         base = CH_ZERO;
      end else if (upper) begin
         base = UPPER_BASE;
      end else begin
         base = LOWER_BASE;
      end
      return base + {4'd0, d};
   endfunction

   function automatic logic [7:0] nil_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h28; // (
         3'd1: c = 8'h6e; // n
         3'd2: c = 8'h69; // i
         3'd3: c = 8'h6c; // l
         3'd4: c = 8'h29; // )
         default: c = 8'h3f;
      endcase
      return c;
   endfunction

endpackage

// ===== src/unsigned_number_to_ascii_formatter_top.sv =====
// number to ascii text formatter: decimal, hex and pointer forms, one char per beat
//
// Input channel req_*: one beat carries a format code (req_op) and a 64-bit
// number (req_value). The block takes one number at a time; req_stall stays
// high from the accepted beat until the last character has moved into the
// output register.
// Result channel rsp_*: one beat per character, most significant first, with
// rsp_last set on the final character of a number.
// Decimal uses a shift-and-add-3 converter, one input bit per cycle; its ten
// BCD digits then move into the digit shift register, leading zeros are
// dropped one digit at a time (the last digit always stays) and the
// characters go out. Hex forms skip the converter but drop leading zeros
// the same way. Pointers send "0x" before their digits, and a zero
// pointer sends "(nil)" instead.
// A stalled output register holds its character; the block waits with it and
// loses nothing.
// Synchronous reset returns to idle and empties the output.
module unsigned_number_to_ascii_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);

   nfmt_pkg::state_type state_ff, state_in;

   logic [63:0] dig_ff, dig_in;
   logic [39:0] bcd_ff, bcd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  pre_ff, pre_in;
   logic        nil_ff, nil_in;
   logic        upper_ff, upper_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        out_free;
   logic        emit_fire;
   logic [7:0]  emit_char;
   logic        emit_last;
   logic [39:0] bcd_adj;
   logic        top_zero;

   assign req_stall     = (state_ff != nfmt_pkg::ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign top_zero      = (dig_ff[63:60] == 4'd0);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // add 3 to each bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < nfmt_pkg::BCD_DIGS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nfmt_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  nfmt_pkg::OP_DEC: state_in = nfmt_pkg::ST_CONV;
                  nfmt_pkg::OP_PTR: state_in = nfmt_pkg::ST_PREFIX;
                  default:          state_in = nfmt_pkg::ST_SKIP;
               endcase
            end
         end
         nfmt_pkg::ST_CONV: begin
            if (cnt_ff == 6'd1) state_in = nfmt_pkg::ST_SKIP;
         end
         nfmt_pkg::ST_SKIP: begin
            if (!(top_zero && cnt_ff > 6'd1)) state_in = nfmt_pkg::ST_EMIT;
         end
         nfmt_pkg::ST_PREFIX: begin
            if (out_free) begin
               if (nil_ff && pre_ff == 3'(nfmt_pkg::NIL_LEN - 1)) begin
                  state_in = nfmt_pkg::ST_IDLE;
               end else if (!nil_ff && pre_ff == 3'd1) begin
                  state_in = nfmt_pkg::ST_SKIP;
               end
            end
         end
         nfmt_pkg::ST_EMIT: begin
            if (out_free && cnt_ff == 6'd1) state_in = nfmt_pkg::ST_IDLE;
         end
         default: state_in = nfmt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      dig_in    = dig_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      pre_in    = pre_ff;
      nil_in    = nil_ff;
      upper_in  = upper_ff;
      emit_fire = 1'b0;
      emit_char = nfmt_pkg::CH_ZERO;
      emit_last = 1'b0;
      case (state_ff)
         nfmt_pkg::ST_IDLE: begin
            if (accept) begin
               pre_in   = 3'd0;
               nil_in   = (req_value == 64'd0);
               upper_in = (req_op == nfmt_pkg::OP_HEX_UP);
               bcd_in   = 40'd0;
               case (req_op)
                  nfmt_pkg::OP_DEC: begin
                     dig_in = {32'd0, req_value[31:0]};
                     cnt_in = 6'(nfmt_pkg::BIN_BITS);
                  end
                  nfmt_pkg::OP_PTR: begin
                     dig_in = req_value;
                     cnt_in = 6'(nfmt_pkg::HEX64_DIG);
                  end
                  default: begin
                     dig_in = {req_value[31:0], 32'd0};
                     cnt_in = 6'(nfmt_pkg::HEX32_DIG);
                  end
               endcase
            end
         end
         nfmt_pkg::ST_CONV: begin
            bcd_in = {bcd_adj[38:0], dig_ff[31]};
            dig_in = {dig_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               dig_in = {bcd_adj[38:0], dig_ff[31], 24'd0};
               cnt_in = 6'(nfmt_pkg::BCD_DIGS);
            end
         end
         nfmt_pkg::ST_SKIP: begin
            if (top_zero && cnt_ff > 6'd1) begin
               dig_in = {dig_ff[59:0], 4'd0};
               cnt_in = cnt_ff - 6'd1;
            end
         end
         nfmt_pkg::ST_PREFIX: begin
            emit_fire = out_free;
            if (nil_ff) begin
               emit_char = nfmt_pkg::nil_char(pre_ff);
               emit_last = (pre_ff == 3'(nfmt_pkg::NIL_LEN - 1));
            end else begin
               emit_char = (pre_ff == 3'd0) ? nfmt_pkg::CH_ZERO : nfmt_pkg::CH_X;
            end
            if (out_free) pre_in = pre_ff + 3'd1;
         end
         nfmt_pkg::ST_EMIT: begin
            emit_fire = out_free;
            emit_char = nfmt_pkg::digit_char(dig_ff[63:60], upper_ff);
            emit_last = (cnt_ff == 6'd1);
            if (out_free) begin
               dig_in = {dig_ff[59:0], 4'd0};
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: begin
            emit_fire = 1'b0;
         end
      endcase

      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfmt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 6'd0;
         pre_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pre_ff       <= pre_in;
      end
      dig_ff      <= dig_in;
      bcd_ff      <= bcd_in;
      nil_ff      <= nil_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // a number in flight blocks the next request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted while a number is in flight");

   // the final character of a number carries last
   a_last_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != nfmt_pkg::ST_IDLE && state_ff != nfmt_pkg::ST_CONV
       && state_in == nfmt_pkg::ST_IDLE) |=> (rsp_valid && rsp_last))
      else $error("number finished without a last character");

   // digit count never runs dry while digits remain to be sent
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfmt_pkg::ST_SKIP || state_ff == nfmt_pkg::ST_EMIT
       || state_ff == nfmt_pkg::ST_CONV) |-> (cnt_ff != 6'd0))
      else $error("digit counter empty while busy");

   // a digit of ten or more sent with lower-case letters comes with a count of at most sixteen
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfmt_pkg::ST_EMIT && !upper_ff && dig_ff[63:60] >= 4'd10)
      |-> (cnt_ff <= 6'(nfmt_pkg::HEX64_DIG)))
      else $error("digit out of range");

endmodule
